// ----- hw/rtl/bgd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants of the button gesture detector: phase codes,
// gesture codes, register map and the structs passed between its modules.
// ----------------------------------------------------------------------------
package bgd_pkg;

  // field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned GestW   = 2;
  localparam int unsigned ApbDW   = 32;
  localparam int unsigned ApbAW   = 3;

  // reset values of the timing windows
  localparam logic [WindowW-1:0] ClickWinRst = 16'd250;
  localparam logic [WindowW-1:0] PressWinRst = 16'd800;

  // register map, selected by paddr[2]
  localparam logic RegClickWin = 1'b0;
  localparam logic RegPressWin = 1'b1;

  // gesture codes
  typedef enum logic [GestW-1:0] {
    GST_CLICK  = 2'd0,
    GST_DOUBLE = 2'd1,
    GST_PRESS  = 2'd2
  } gesture_e;

  // detector phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_HIGH1 = 5'b00010,
    PH_LOW1  = 5'b00100,
    PH_HIGH2 = 5'b01000,
    PH_HOLD  = 5'b10000
  } phase_e;

  // timing configuration
  typedef struct packed {
    logic [WindowW-1:0] click_win;
    logic [WindowW-1:0] press_win;
  } cfg_t;

  // result handed from the detector to the output stage
  typedef struct packed {
    logic     valid;
    gesture_e gesture;
  } res_t;

endpackage

// ----- hw/rtl/bgd_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_in_if
// Sample channel: button level and millisecond timestamp, valid/ready.
// ----------------------------------------------------------------------------
interface bgd_in_if;
  logic        valid;
  logic        ready;
  logic        level;
  logic [31:0] now_ms;

  modport source (output valid, output level, output now_ms, input ready);
  modport sink   (input valid, input level, input now_ms, output ready);
endinterface

// ----- hw/rtl/bgd_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_out_if
// Gesture channel: detected gesture code, valid/ready.
// ----------------------------------------------------------------------------
interface bgd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface

// ----- hw/rtl/bgd_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_cfg
// APB register block holding the click and long-press windows.
// ----------------------------------------------------------------------------
module bgd_cfg import bgd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAW-1:0] paddr,
  input  logic [ApbDW-1:0] pwdata,
  output logic [ApbDW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegClickWin: cfg_d.click_win = pwdata[WindowW-1:0];
        RegPressWin: cfg_d.press_win = pwdata[WindowW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_win <= ClickWinRst;
      cfg_q.press_win <= PressWinRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      RegClickWin: prdata = {{(ApbDW-WindowW){1'b0}}, cfg_q.click_win};
      RegPressWin: prdata = {{(ApbDW-WindowW){1'b0}}, cfg_q.press_win};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

  // a write to the click window lands in the next cycle
  a_click_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (reg_sel == RegClickWin)) |=> (cfg_q.click_win == $past(pwdata[WindowW-1:0])))
    else $error("click window write lost");

endmodule

// ----- hw/rtl/bgd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_core
// Input sample register and the five-phase gesture state machine.
// ----------------------------------------------------------------------------
module bgd_core import bgd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  bgd_in_if.sink in_if,
  input  logic   res_ready_i,
  output res_t   res_o
);

  logic             s1_valid_q, s1_valid_d;
  logic             s1_level_q;
  logic [TimeW-1:0] s1_now_q;
  logic             in_acc;
  logic             adv;

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] edge_q, edge_d;
  logic [TimeW-1:0] elapsed;
  logic             over_press;
  logic             over_click;
  logic             emit;
  gesture_e         gest;

  // sample stage moves on when the output stage has room
  assign adv         = s1_valid_q & res_ready_i;
  assign in_if.ready = ~s1_valid_q | adv;
  assign in_acc      = in_if.valid & in_if.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_level_q <= in_if.level;
      s1_now_q   <= in_if.now_ms;
    end
  end

  // modulo 2^32 time since the first rising edge
  assign elapsed    = s1_now_q - edge_q;
  assign over_press = elapsed > {{(TimeW-WindowW){1'b0}}, cfg_i.press_win};
  assign over_click = elapsed > {{(TimeW-WindowW){1'b0}}, cfg_i.click_win};

  // gesture state machine
  always_comb begin
    phase_d = phase_q;
    edge_d  = edge_q;
    emit    = 1'b0;
    gest    = GST_CLICK;
    unique case (phase_q)
      PH_HIGH1: begin
        if (!s1_level_q) begin
          phase_d = PH_LOW1;
        end else if (over_press) begin
          emit    = 1'b1;
          gest    = GST_PRESS;
          phase_d = PH_HOLD;
        end
      end
      PH_LOW1: begin
        // timeout wins over a new press in the same sample
        if (over_click) begin
          emit    = 1'b1;
          gest    = GST_CLICK;
          phase_d = PH_IDLE;
        end else if (s1_level_q) begin
          phase_d = PH_HIGH2;
        end
      end
      PH_HIGH2: begin
        if (!s1_level_q) begin
          emit    = 1'b1;
          gest    = GST_DOUBLE;
          phase_d = PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (!s1_level_q) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        if (s1_level_q) begin
          phase_d = PH_HIGH1;
          edge_d  = s1_now_q;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      edge_q  <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      edge_q  <= edge_d;
    end
  end

  assign res_o.valid   = adv & emit;
  assign res_o.gesture = gest;

  // state moves only when a sample is consumed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(phase_q) && $stable(edge_q)))
    else $error("phase changed without a sample");

  // only the three active phases can report a gesture
  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (phase_q == PH_HIGH1 || phase_q == PH_LOW1 || phase_q == PH_HIGH2))
    else $error("gesture from an inactive phase");

  // a long press always leads to the hold phase
  a_press_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.gesture == GST_PRESS) |=> (phase_q == PH_HOLD))
    else $error("long press without hold");

endmodule

// ----- hw/rtl/bgd_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_out_reg
// Result register driving the gesture channel, refilled in the same cycle
// the waiting item is taken.
// ----------------------------------------------------------------------------
module bgd_out_reg import bgd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_t      res_i,
  output logic      take_o,
  bgd_out_if.source out_if
);

  logic     valid_q, valid_d;
  gesture_e gest_q;

  // room when empty or when the held item leaves this cycle
  assign take_o = ~valid_q | out_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (out_if.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      gest_q <= res_i.gesture;
    end
  end

  assign out_if.valid   = valid_q;
  assign out_if.gesture = gest_q;

  // never overwrite an item that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> (!valid_q || out_if.ready))
    else $error("result register overwritten");

endmodule

// ----- hw/rtl/button_gesture_detector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_unit
// Click, double click and long press detection on sampled button levels.
// ----------------------------------------------------------------------------
// Usage
//   in_if  : one item per sample, level (1 = pressed) and a free-running
//            32-bit millisecond timestamp, accepted on valid & ready
//   out_if : zero or one gesture item per sample (0 click, 1 double click,
//            2 long press), taken on valid & ready
//   APB    : reg 0 (0x0) click window, reg 1 (0x4) long-press window, 16 bits
//            each; user writes only while the block is idle (not enforced)
// Timing
//   a sample is held in the sample register, processed by the state machine,
//   and its gesture is registered in the result register that drives out_if;
//   one sample per cycle is taken while the output side keeps up, set by
//   the state update with one subtract and two compares
// Reset
//   phase returns to idle, edge time to zero, windows to 250 and 800 ms,
//   both channels empty
// Back-pressure
//   the result register holds a waiting gesture; the sample stage stalls,
//   and in turn in_if.ready drops, only while that register is full and
//   not being taken
// ----------------------------------------------------------------------------
module button_gesture_detector_unit import bgd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  bgd_in_if.sink           in_if,
  bgd_out_if.source        out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAW-1:0] paddr,
  input  logic [ApbDW-1:0] pwdata,
  output logic [ApbDW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  res_t res;
  logic take;

  // configuration registers
  bgd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sample register and state machine
  bgd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_if       (in_if),
    .res_ready_i (take),
    .res_o       (res)
  );

  // result register
  bgd_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .take_o (take),
    .out_if (out_if)
  );

endmodule
